// File: design/pressure_temp_compensation_macros.svh
`ifndef PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMP_COMPENSATION_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define PTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define PTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ptc_pkg.sv
package ptc_pkg;

	localparam int PROM_W = 16;
	localparam int IDX_W  = 3;
	localparam int RAW_W  = 24;
	localparam int OUT_W  = 32;
	localparam int WIDE_W = 72;

	typedef enum logic [IDX_W-1:0] {
		REG_C1,
		REG_C2,
		REG_C3,
		REG_C4,
		REG_C5,
		REG_C6,
		REG_SENSOR_TYPE
	} reg_idx_t;

	typedef struct packed {
		logic [PROM_W-1:0] c1;
		logic [PROM_W-1:0] c2;
		logic [PROM_W-1:0] c3;
		logic [PROM_W-1:0] c4;
		logic [PROM_W-1:0] c5;
		logic [PROM_W-1:0] c6;
		logic              two_bar;
	} cfg_t;

	localparam logic signed [19:0] TEMP_REF = 20'sd2000;
	// deviation below which the part is under -15 C
	localparam logic signed [18:0] COLD_DEV = 19'sd3500;

	localparam logic [6:0] SH_TEMP    = 7'd23;
	localparam logic [6:0] SH_OFF_2B  = 7'd6;
	localparam logic [6:0] SH_OFF_30B = 7'd7;
	localparam logic [6:0] SH_SNS_2B  = 7'd7;
	localparam logic [6:0] SH_SNS_30B = 7'd8;
	localparam logic [6:0] SH_PROD    = 7'd21;
	localparam logic [6:0] SH_P_2B    = 7'd15;
	localparam logic [6:0] SH_P_30B   = 7'd13;

	// signed shift that rounds toward zero
	function automatic logic signed [WIDE_W-1:0] div_pow2(
		input logic signed [WIDE_W-1:0] x,
		input logic [6:0]               k
	);
		logic signed [WIDE_W-1:0] bias;
		bias = x[WIDE_W-1] ? ((WIDE_W'(1) << k) - WIDE_W'(1)) : '0;
		return (x + bias) >>> k;
	endfunction

endpackage

// File: design/pressure_temp_compensation.sv
// channel   direction  handshake              payload
// cfg       in         cfg_wr_en              cfg_index, cfg_data
// in        in         in_valid / in_ready    raw_pressure, raw_temperature
// out       out        out_valid / out_ready  temperature_centi, pressure_scaled
//
// ten register stages, one word in and one word out per cycle while out_ready is high
// the wide d1 * sens product is split in two partial products over two stages
// reset clears the stage valid bits and loads the calibration defaults
// a stall holds a stage only while the stage after it is full, so bubbles close up
module pressure_temp_compensation
	import ptc_pkg::*;
#(
	parameter int ADC_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [PROM_W-1:0]       cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [RAW_W-1:0]        raw_pressure,
	input  logic [RAW_W-1:0]        raw_temperature,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] temperature_centi,
	output logic signed [OUT_W-1:0] pressure_scaled
);

	localparam int NSTG = 10;
	localparam logic [RAW_W-1:0] ADC_MASK = RAW_W'((64'd1 << ADC_BITS) - 64'd1);

	cfg_t cfg;

	ptc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_wr_en),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// stage control
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] adv;

	always_comb begin
		adv[NSTG-1] = !vld_q[NSTG-1] || out_ready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[NSTG-1];

	// stage 1: mask raw words, dT
	logic [RAW_W-1:0]    d1_m, d2_m;
	logic [RAW_W-1:0]    d1_s1;
	logic signed [24:0]  dt_s1;

	assign d1_m = raw_pressure & ADC_MASK;
	assign d2_m = raw_temperature & ADC_MASK;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			d1_s1 <= d1_m;
			dt_s1 <= $signed({1'b0, d2_m}) - $signed({1'b0, cfg.c5, 8'h00});
		end
	end

	// stage 2: products of dT
	logic [RAW_W-1:0]   d1_s2;
	logic signed [41:0] tc_s2, c4dt_s2, c3dt_s2;
	logic signed [49:0] dt2_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			d1_s2   <= d1_s1;
			tc_s2   <= dt_s1 * $signed({1'b0, cfg.c6});
			c4dt_s2 <= dt_s1 * $signed({1'b0, cfg.c4});
			c3dt_s2 <= dt_s1 * $signed({1'b0, cfg.c3});
			dt2_s2  <= dt_s1 * dt_s1;
		end
	end

	// stage 3: temperature deviation, T2, first-order offset and sensitivity
	logic signed [17:0] q_w;
	logic [17:0]        t2_w;
	logic [49:0]        dt2x3;
	logic [50:0]        dt2x7;
	logic signed [35:0] off_base, sens_base, off_div, sens_div, off1_w, sens1_w;

	assign q_w   = 18'(div_pow2(WIDE_W'(tc_s2), SH_TEMP));
	assign dt2x3 = 50'(dt2_s2[48:0]) * 50'd3;
	assign dt2x7 = 51'(dt2_s2[48:0]) * 51'd7;

	always_comb begin
		if (q_w[17]) begin
			t2_w = cfg.two_bar ? dt2_s2[48:31] : 18'(dt2x3 >> 33);
		end else begin
			t2_w = cfg.two_bar ? 18'd0 : 18'(dt2x7 >> 37);
		end
	end

	always_comb begin
		if (cfg.two_bar) begin
			off_base  = 36'({cfg.c2, 17'h0});
			sens_base = 36'({cfg.c1, 16'h0});
			off_div   = 36'(div_pow2(WIDE_W'(c4dt_s2), SH_OFF_2B));
			sens_div  = 36'(div_pow2(WIDE_W'(c3dt_s2), SH_SNS_2B));
		end else begin
			off_base  = 36'({cfg.c2, 16'h0});
			sens_base = 36'({cfg.c1, 15'h0});
			off_div   = 36'(div_pow2(WIDE_W'(c4dt_s2), SH_OFF_30B));
			sens_div  = 36'(div_pow2(WIDE_W'(c3dt_s2), SH_SNS_30B));
		end
		off1_w  = off_base + off_div;
		sens1_w = sens_base + sens_div;
	end

	logic [RAW_W-1:0]   d1_s3;
	logic signed [17:0] q_s3;
	logic [17:0]        t2_s3;
	logic signed [35:0] off1_s3, sens1_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			d1_s3    <= d1_s2;
			q_s3     <= q_w;
			t2_s3    <= t2_w;
			off1_s3  <= off1_w;
			sens1_s3 <= sens1_w;
		end
	end

	// stage 4: squares and output temperature
	logic signed [18:0] cold_w;
	logic signed [35:0] sq_w;
	logic signed [37:0] csq_w;

	assign cold_w = 19'(q_s3) + COLD_DEV;
	assign sq_w   = q_s3 * q_s3;
	assign csq_w  = cold_w * cold_w;

	logic [RAW_W-1:0]   d1_s4;
	logic [33:0]        sq_s4, csq_s4;
	logic               low_s4, cold_s4;
	logic signed [19:0] temp_s4;
	logic signed [35:0] off1_s4, sens1_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			d1_s4    <= d1_s3;
			sq_s4    <= 34'(sq_w);
			csq_s4   <= 34'(csq_w);
			low_s4   <= q_s3[17];
			cold_s4  <= cold_w[18];
			temp_s4  <= 20'(q_s3) + TEMP_REF - $signed({2'b00, t2_s3});
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
		end
	end

	// stage 5: second-order offset and sensitivity
	logic [39:0] sq40, csq40, off2_w, sens2_w;

	assign sq40  = 40'(sq_s4);
	assign csq40 = 40'(csq_s4);

	always_comb begin
		off2_w  = '0;
		sens2_w = '0;
		if (cfg.two_bar) begin
			if (low_s4) begin
				off2_w  = (sq40 * 40'd61) >> 4;
				sens2_w = sq40 << 1;
			end
			if (cold_s4) begin
				off2_w  = off2_w + csq40 * 40'd20;
				sens2_w = sens2_w + csq40 * 40'd12;
			end
		end else begin
			if (low_s4) begin
				off2_w  = (sq40 * 40'd3) >> 1;
				sens2_w = (sq40 * 40'd5) >> 3;
			end else begin
				off2_w = sq40 >> 4;
			end
			if (cold_s4) begin
				off2_w  = off2_w + csq40 * 40'd7;
				sens2_w = sens2_w + (csq40 << 2);
			end
		end
	end

	logic [RAW_W-1:0]   d1_s5;
	logic [39:0]        off2_s5, sens2_s5;
	logic signed [19:0] temp_s5;
	logic signed [35:0] off1_s5, sens1_s5;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			d1_s5    <= d1_s4;
			off2_s5  <= off2_w;
			sens2_s5 <= sens2_w;
			temp_s5  <= temp_s4;
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
		end
	end

	// stage 6: final offset and sensitivity
	logic [RAW_W-1:0]   d1_s6;
	logic signed [40:0] off_s6, sens_s6;
	logic signed [19:0] temp_s6;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			d1_s6   <= d1_s5;
			off_s6  <= 41'(off1_s5) - $signed({1'b0, off2_s5});
			sens_s6 <= 41'(sens1_s5) - $signed({1'b0, sens2_s5});
			temp_s6 <= temp_s5;
		end
	end

	// stage 7: d1 * sens as two partial products
	logic [44:0]        pp_lo_s7;
	logic signed [44:0] pp_hi_s7;
	logic signed [40:0] off_s7;
	logic signed [19:0] temp_s7;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			pp_lo_s7 <= 45'(d1_s6) * 45'(sens_s6[20:0]);
			pp_hi_s7 <= $signed({1'b0, d1_s6}) * $signed(sens_s6[40:21]);
			off_s7   <= off_s6;
			temp_s7  <= temp_s6;
		end
	end

	// stage 8: combine partial products
	logic signed [65:0] prod_s8;
	logic signed [40:0] off_s8;
	logic signed [19:0] temp_s8;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			prod_s8 <= 66'((WIDE_W'(pp_hi_s7) <<< 21) + WIDE_W'(pp_lo_s7));
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
	end

	// stage 9: scale product and remove offset
	logic signed [45:0] pd_s9;
	logic signed [19:0] temp_s9;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			pd_s9   <= 46'(div_pow2(WIDE_W'(prod_s8), SH_PROD) - WIDE_W'(off_s8));
			temp_s9 <= temp_s8;
		end
	end

	// stage 10: output register
	logic signed [OUT_W-1:0] pres_s10, temp_s10;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			pres_s10 <= OUT_W'(div_pow2(WIDE_W'(pd_s9), cfg.two_bar ? SH_P_2B : SH_P_30B));
			temp_s10 <= OUT_W'(temp_s9);
		end
	end

	assign temperature_centi = temp_s10;
	assign pressure_scaled   = pres_s10;

endmodule

// File: design/ptc_cfg_regs.sv
module ptc_cfg_regs
	import ptc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [PROM_W-1:0] wr_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{c1: '0, c2: '0, c3: '0, c4: '0, c5: '0, c6: '0, two_bar: 1'b1};
		end else if (wr_en) begin
			case (reg_idx_t'(wr_idx))
				REG_C1:          cfg_q.c1 <= wr_data;
				REG_C2:          cfg_q.c2 <= wr_data;
				REG_C3:          cfg_q.c3 <= wr_data;
				REG_C4:          cfg_q.c4 <= wr_data;
				REG_C5:          cfg_q.c5 <= wr_data;
				REG_C6:          cfg_q.c6 <= wr_data;
				REG_SENSOR_TYPE: cfg_q.two_bar <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/ptc_chk.sv
`include "pressure_temp_compensation_macros.svh"

module ptc_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] temperature_centi,
	input logic signed [31:0] pressure_scaled
);

	// words accepted but not yet delivered
	logic [4:0] cnt_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 5'(in_acc) - 5'(out_acc);
		end
	end

	`PTC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "out word dropped")
	`PTC_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(temperature_centi) && $stable(pressure_scaled), "out word changed under stall")
	`PTC_ASSERT_IMP(a_no_invent, clk, arst_n, out_valid, cnt_q != 5'd0, "out word without in word")
	`PTC_ASSERT_IMP(a_flow, clk, arst_n, out_ready, in_ready, "in side stalled while out side free")

endmodule

bind pressure_temp_compensation ptc_chk u_ptc_chk (.*);
